FILE: hw/rtl/rdd_pkg.sv
// ----------------------------------------------------------------------------
// rdd_pkg
// Shared types and constants for the relocation delta decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rdd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned BlobW   = 31;
  localparam int unsigned GatherW = 56;
  localparam int unsigned TakenW  = 3;
  localparam int unsigned LenW    = 4;

  // Entry lengths in bytes
  localparam logic [LenW-1:0] LenShort = 4'd2;
  localparam logic [LenW-1:0] LenMid   = 4'd3;
  localparam logic [LenW-1:0] LenLong  = 4'd8;

  // Absolute offset code standing for the footer word (-1)
  localparam logic [WordW-1:0] FooterCode = 32'h3fff_ffff;

  localparam logic [WordW-1:0] TargetShiftRst = 32'h0000_0000;
  localparam logic [BlobW-1:0] BlobStartRst   = 31'h7fff_ffff;

  typedef enum logic {
    CFG_TARGET_SHIFT = 1'b0,
    CFG_BLOB_START   = 1'b1
  } cfg_idx_e;

  // One input beat
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             list_start;
  } in_beat_t;

  // One decoded entry
  typedef struct packed {
    logic [WordW-1:0] entry_offset;
    logic [WordW-1:0] original_value;
    logic [WordW-1:0] patched_value;
    logic             bad_offset;
  } result_t;

endpackage : rdd_pkg

`default_nettype wire

FILE: hw/rtl/rdd_in_reg.sv
// ----------------------------------------------------------------------------
// rdd_in_reg
// Input register: holds one byte beat until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_in_reg
  import rdd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_beat_i,
  input  logic     take_i,      // decode stage can consume a beat
  output logic     fire_o,      // held beat consumed this cycle
  output in_beat_t beat_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  assign fire_o     = valid_q && take_i;
  assign in_ready_o = !valid_q || take_i;
  assign beat_o     = beat_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= in_beat_i;
    end
  end

endmodule : rdd_in_reg

`default_nettype wire

FILE: hw/rtl/rdd_decode.sv
// ----------------------------------------------------------------------------
// rdd_decode
// Entry gathering state and single-pass decode of the completing byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_decode
  import rdd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  in_beat_t         beat_i,
  input  logic [WordW-1:0] target_shift_i,
  input  logic [BlobW-1:0] blob_start_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  logic [WordW-1:0]   last_off_q, last_off_d;
  logic [WordW-1:0]   last_cont_q, last_cont_d;
  logic [GatherW-1:0] gath_q, gath_d;
  logic [TakenW-1:0]  taken_q, taken_d;
  logic [LenW-1:0]    len_q, len_d;

  logic [WordW-1:0]  off_base, cont_base;
  logic [TakenW-1:0] taken_eff;
  logic              is_first, is_more;
  logic [ByteW-1:0]  b, b0, b1;
  logic [WordW-1:0]  step, delta, offs, cont;
  logic [2:0]        step_mul;

  assign b         = beat_i.data_byte;
  assign off_base  = beat_i.list_start ? '0 : last_off_q;
  assign cont_base = beat_i.list_start ? '0 : last_cont_q;
  assign taken_eff = beat_i.list_start ? '0 : taken_q;
  assign is_first  = (taken_eff == '0);
  assign is_more   = (({1'b0, taken_eff} + 4'd1) < len_q);

  // Value of the entry completed by this byte
  always_comb begin
    b0       = '0;
    b1       = '0;
    step_mul = '0;
    step     = '0;
    delta    = '0;
    offs     = '0;
    cont     = '0;
    if (len_q == LenShort) begin
      b0       = gath_q[7:0];
      step_mul = {1'b0, b0[6:5]} + 3'd1;
      step     = {27'd0, step_mul, 2'b00};
      delta    = {{19{b0[4]}}, b0[4:0], b};
      offs     = off_base + step;
      cont     = cont_base + delta;
    end else if (len_q == LenMid) begin
      b0       = gath_q[15:8];
      b1       = gath_q[7:0];
      step_mul = {1'b0, b0[5:4]} + 3'd1;
      step     = {27'd0, step_mul, 2'b00};
      delta    = {{12{b0[3]}}, b0[3:0], b1, b};
      offs     = off_base + step;
      cont     = cont_base + delta;
    end else begin
      offs = (gath_q[55:24] == FooterCode) ? '1 : gath_q[55:24];
      cont = {gath_q[23:0], b};
    end
  end

  assign res_valid_o          = fire_i && !is_first && !is_more;
  assign res_o.entry_offset   = offs;
  assign res_o.original_value = cont;
  assign res_o.patched_value  = cont + target_shift_i;
  assign res_o.bad_offset     = offs[WordW-1] ? (offs != '1) : (offs[BlobW-1:0] >= blob_start_i);

  always_comb begin
    last_off_d  = last_off_q;
    last_cont_d = last_cont_q;
    gath_d      = gath_q;
    taken_d     = taken_q;
    len_d       = len_q;
    if (fire_i) begin
      last_off_d  = off_base;
      last_cont_d = cont_base;
      if (is_first) begin
        if (b[7]) begin
          len_d = LenShort;
        end else if (b[6]) begin
          len_d = LenMid;
        end else begin
          len_d = LenLong;
        end
        gath_d  = {{(GatherW-ByteW){1'b0}}, b};
        taken_d = 3'd1;
      end else if (is_more) begin
        gath_d  = {gath_q[GatherW-ByteW-1:0], b};
        taken_d = taken_eff + 3'd1;
      end else begin
        gath_d      = '0;
        taken_d     = '0;
        len_d       = '0;
        last_off_d  = offs;
        last_cont_d = cont;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_off_q  <= '0;
      last_cont_q <= '0;
      gath_q      <= '0;
      taken_q     <= '0;
      len_q       <= '0;
    end else begin
      last_off_q  <= last_off_d;
      last_cont_q <= last_cont_d;
      gath_q      <= gath_d;
      taken_q     <= taken_d;
      len_q       <= len_d;
    end
  end

endmodule : rdd_decode

`default_nettype wire

FILE: hw/rtl/rdd_out_reg.sv
// ----------------------------------------------------------------------------
// rdd_out_reg
// Result register: holds one decoded entry until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_out_reg
  import rdd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    take_o,       // register free or emptying this cycle
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign take_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule : rdd_out_reg

`default_nettype wire

FILE: hw/rtl/relocation_delta_decoder.sv
// ----------------------------------------------------------------------------
// relocation_delta_decoder
// Byte-serial decoder for delta-coded relocation entries.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat contents
//  ---------+-----+----------------------------------------------------------
//  s_axis   | in  | tdata[7:0] data_byte, tuser list_start
//  m_axis   | out | tdata[31:0] entry_offset, [63:32] original_value,
//           |     | [95:64] patched_value; tuser bad_offset
//  cfg      | in  | idx 0 target_shift (32 b), idx 1 blob_start (31 b)
//
//  One byte per clock sustained while the sink keeps up. A byte is held in the
//  input register, decoded in one pass against the gathering state and, if it
//  ends an entry, lands in the result register.
//  Reset clears the gathering state, previous offset and contents, and sets
//  the registers to shift 0 and blob start 0x7fffffff.
//  A stalled sink stops the input only once both registers hold a beat.
//
`default_nettype none

module relocation_delta_decoder
  import rdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] list_start
  // decoded entries out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [31:0] entry_offset, [63:32] original_value,
                                      // [95:64] patched_value
  output logic        m_axis_tuser,   // [0] bad_offset
  // register writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [WordW-1:0] target_shift_q;
  logic [BlobW-1:0] blob_start_q;

  in_beat_t in_beat, beat;
  logic     take, fire;
  logic     res_valid;
  result_t  res, out_res;

  // Configuration registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_shift_q <= TargetShiftRst;
      blob_start_q   <= BlobStartRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_e'(cfg_idx_i) == CFG_TARGET_SHIFT) begin
        target_shift_q <= cfg_data_i;
      end else begin
        blob_start_q <= cfg_data_i[BlobW-1:0];
      end
    end
  end

  assign in_beat.data_byte  = s_axis_tdata;
  assign in_beat.list_start = s_axis_tuser;

  rdd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_beat_i  (in_beat),
    .take_i     (take),
    .fire_o     (fire),
    .beat_o     (beat)
  );

  rdd_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .beat_i         (beat),
    .target_shift_i (target_shift_q),
    .blob_start_i   (blob_start_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  rdd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {out_res.patched_value, out_res.original_value, out_res.entry_offset};
  assign m_axis_tuser = out_res.bad_offset;

endmodule : relocation_delta_decoder

`default_nettype wire

FILE: hw/rtl/rdd_checker.sv
// ----------------------------------------------------------------------------
// rdd_checker
// Port-level checks for the relocation delta decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_checker
  import rdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [WordW-1:0] shift_q;

  // Shadow of the shift register as seen on the write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= TargetShiftRst;
    end else if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_TARGET_SHIFT)) begin
      shift_q <= cfg_data_i;
    end
  end

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Patched value is original plus the configured shift
  a_patch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[95:64] == m_axis_tdata[63:32] + shift_q))
    else $error("patched value does not match shift");

  // Footer offset is never flagged
  a_footer_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[31:0] == 32'hffff_ffff) |-> !m_axis_tuser)
    else $error("footer offset flagged bad");

  // Any other negative offset is flagged
  a_neg_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31] && (m_axis_tdata[31:0] != 32'hffff_ffff)
      |-> m_axis_tuser)
    else $error("negative offset not flagged");

endmodule : rdd_checker

bind relocation_delta_decoder rdd_checker u_rdd_checker (.*);

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the relocation delta decoder.
// A byte-accurate model of the entry decoder predicts every decoded entry.
// A short directed run covers the entry forms and their field extremes.
// Eight register settings then each carry random entries, broken entries and
// noise bytes, with random idling on one or both streams in the first six.
// ----------------------------------------------------------------------------

module tb;
  import rdd_pkg::*;

  // Cycles without any accepted beat before the run is abandoned
  localparam int unsigned StallLimit = 2000;
  // Settle time after the last entry: two register stages plus margin
  localparam int unsigned DrainCycles = 8;
  // Random bytes per register setting
  localparam int unsigned PhaseBytes = 250;

  // --------------------------------------------------------------------------
  // Scoreboard: decoder model plus queue of predicted entries
  // --------------------------------------------------------------------------
  class reloc_scoreboard;
    logic [WordW-1:0]   shift;
    logic [BlobW-1:0]   blob;
    logic [WordW-1:0]   prev_offset;
    logic [WordW-1:0]   prev_contents;
    logic [GatherW-1:0] gathered;
    int unsigned        taken;
    logic [LenW-1:0]    len;
    result_t            pending[$];
    int unsigned        errors;

    function new();
      shift         = TargetShiftRst;
      blob          = BlobStartRst;
      prev_offset   = '0;
      prev_contents = '0;
      gathered      = '0;
      taken         = 0;
      len           = '0;
      errors        = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [WordW-1:0] value);
      if (idx == CFG_TARGET_SHIFT) shift = value;
      else blob = value[BlobW-1:0];
    endfunction

    // Accepted input beat: advance the model, queue an entry if one completes
    function void note_byte(logic [ByteW-1:0] b, logic list_start);
      logic [WordW-1:0] offs;
      logic [WordW-1:0] cont;
      logic [WordW-1:0] delta;
      logic [WordW-1:0] step;
      logic [ByteW-1:0] b0;
      logic [ByteW-1:0] b1;
      result_t          r;
      // list start drops any half-gathered entry and the history
      if (list_start) begin
        prev_offset   = '0;
        prev_contents = '0;
        taken         = 0;
      end
      if (taken == 0) begin
        if (b[7]) len = LenShort;
        else if (b[6]) len = LenMid;
        else len = LenLong;
        gathered = GatherW'(b);
        taken    = 1;
        return;
      end
      if (taken + 1 < len) begin
        gathered = {gathered[GatherW-9:0], b};
        taken++;
        return;
      end
      case (len)
        LenShort: begin
          b0    = gathered[7:0];
          step  = WordW'({b0[6:5], 2'b00}) + 32'd4;
          delta = {{19{b0[4]}}, b0[4:0], b};
          offs  = prev_offset + step;
          cont  = prev_contents + delta;
        end
        LenMid: begin
          b0    = gathered[15:8];
          b1    = gathered[7:0];
          step  = WordW'({b0[5:4], 2'b00}) + 32'd4;
          delta = {{12{b0[3]}}, b0[3:0], b1, b};
          offs  = prev_offset + step;
          cont  = prev_contents + delta;
        end
        default: begin
          // big-endian absolute offset then absolute contents
          offs = gathered[55:24];
          if (offs == FooterCode) offs = '1;
          cont = {gathered[23:0], b};
        end
      endcase
      r.entry_offset   = offs;
      r.original_value = cont;
      r.patched_value  = cont + shift;
      r.bad_offset     = offs[31] ? (offs != '1) : (offs >= {1'b0, blob});
      prev_offset   = offs;
      prev_contents = cont;
      gathered      = '0;
      taken         = 0;
      len           = '0;
      pending.push_back(r);
    endfunction

    // Accepted output beat: compare against the oldest prediction
    function void check_entry(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected entry off %h orig %h patch %h bad %b", $time,
                   got.entry_offset, got.original_value, got.patched_value,
                   got.bad_offset);
        return;
      end
      exp_r = pending.pop_front();
      if (got.entry_offset   !== exp_r.entry_offset   ||
          got.original_value !== exp_r.original_value ||
          got.patched_value  !== exp_r.patched_value  ||
          got.bad_offset     !== exp_r.bad_offset) begin
        errors++;
        if (errors <= 10)
          $display("%0t: entry mismatch exp off %h orig %h patch %h bad %b,",
                   $time, exp_r.entry_offset, exp_r.original_value,
                   exp_r.patched_value, exp_r.bad_offset,
                   " got off %h orig %h patch %h bad %b", got.entry_offset,
                   got.original_value, got.patched_value, got.bad_offset);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [31:0] cfg_data_i    = '0;

  always #1 clk_i = ~clk_i;

  relocation_delta_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  reloc_scoreboard sb = new();

  // idling switches, changed per register setting
  bit src_gaps  = 1'b0;
  bit sink_gaps = 1'b0;
  // a truncated entry forces list start on the next one
  bit force_start = 1'b0;
  int unsigned idle_cycles = 0;
  // input beats accepted so far
  int unsigned sent_count = 0;

  // --------------------------------------------------------------------------
  // Monitor: result handshake sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.entry_offset   = m_axis_tdata[31:0];
      got.original_value = m_axis_tdata[63:32];
      got.patched_value  = m_axis_tdata[95:64];
      got.bad_offset     = m_axis_tuser;
      sb.check_entry(got);
    end
  end

  // Watchdog: counts cycles with no beat moving on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sink: random back-pressure bursts while sink idling is switched on
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_gaps && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One byte beat; returns at the edge where it is taken, already noted
  task automatic send_byte(input logic [7:0] b, input logic list_start);
    if (src_gaps && $urandom_range(0, 9) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= list_start;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, list_start);
    sent_count++;
  endtask

  // Register write; only called with nothing in flight
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Stop the source and let every predicted entry come out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One random entry, or a noise byte; may be cut short
  task automatic send_entry();
    logic [7:0]  bytes[8];
    logic [31:0] word;
    int unsigned n;
    int unsigned kind;
    int unsigned sel;
    logic        ls;
    kind = $urandom_range(0, 99);
    ls   = force_start || ($urandom_range(0, 15) == 0);
    force_start = 1'b0;
    if (kind < 40) begin
      // 2-byte form: step bits 6..5, 13-bit delta
      word     = $urandom;
      bytes[0] = {1'b1, word[14:13], word[12:8]};
      bytes[1] = word[7:0];
      n = 2;
    end else if (kind < 70) begin
      // 3-byte form: step bits 5..4, 20-bit delta
      word     = $urandom;
      bytes[0] = {2'b01, word[21:20], word[19:16]};
      bytes[1] = word[15:8];
      bytes[2] = word[7:0];
      n = 3;
    end else if (kind < 90) begin
      // 8-byte absolute form; offsets mostly near the blob start settings
      sel = $urandom_range(0, 9);
      if (sel < 5) word = $urandom_range(0, 32'h3000);
      else if (sel < 7) word = FooterCode;
      else if (sel < 8) word = 32'h3fff_fffe;
      else word = {2'b00, 30'($urandom)};
      bytes[0] = word[31:24];
      bytes[1] = word[23:16];
      bytes[2] = word[15:8];
      bytes[3] = word[7:0];
      word     = $urandom;
      bytes[4] = word[31:24];
      bytes[5] = word[23:16];
      bytes[6] = word[15:8];
      bytes[7] = word[7:0];
      n = 8;
    end else begin
      send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    // broken entry: stop part way, restart the list on the next one
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, n - 1);
      force_start = 1'b1;
    end
    for (int unsigned i = 0; i < n; i++)
      send_byte(bytes[i], (i == 0) ? ls : 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] shift_v;
    logic [31:0] blob_v;
    int unsigned start_count;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats, reset register values
    // 2-byte, largest positive delta, longest step, opening the list
    send_byte(8'hef, 1'b1);
    send_byte(8'hff, 1'b0);
    // 2-byte, most negative delta
    send_byte(8'h90, 1'b0);
    send_byte(8'h00, 1'b0);
    // 3-byte, most negative delta, shortest step
    send_byte(8'h48, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // 3-byte, largest positive delta, longest step
    send_byte(8'h77, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    // 8-byte footer code: offset -1, contents all ones
    send_byte(8'h3f, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    // 2-byte from -1: offset wraps through zero
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    // list start in the middle of a 3-byte entry drops it
    send_byte(8'h48, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(8'h23, 1'b0);
    drain();

    // Random part: one register setting per phase, extremes first
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin shift_v = 32'h8000_0000; blob_v = 32'h0000_0000; end
        1: begin shift_v = 32'h7fff_ffff; blob_v = 32'h7fff_ffff; end
        2: begin shift_v = 32'hffff_ffff; blob_v = 32'h0000_0001; end
        3: begin shift_v = 32'h0000_0000; blob_v = $urandom_range(0, 32'h3000); end
        default: begin
          shift_v = $urandom;
          blob_v  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32'h3000)
                                                : {1'b0, 31'($urandom)};
        end
      endcase
      write_reg(CFG_TARGET_SHIFT, shift_v);
      write_reg(CFG_BLOB_START, blob_v);
      // idling varies by phase; none at all in the last two
      src_gaps  = (p < 6) && (p != 2);
      sink_gaps = (p < 6) && (p != 4);
      start_count = sent_count;
      send_byte(8'($urandom), 1'b1);
      while (sent_count - start_count < PhaseBytes) begin
        send_entry();
      end
      // finish any open entry so the registers change between entries
      while (sb.taken != 0) send_byte(8'($urandom), 1'b0);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rdd_pkg.sv
hw/rtl/rdd_in_reg.sv
hw/rtl/rdd_decode.sv
hw/rtl/rdd_out_reg.sv
hw/rtl/relocation_delta_decoder.sv
hw/rtl/rdd_checker.sv
tb/sv/tb.sv
